/* rtl/nbc_pkg.sv */
// Shared types, constants and round functions for the NLFSR block cipher.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package nbc_pkg;

  // Cipher geometry.
  localparam int ROUNDS    = 528;
  localparam int WORD_W    = 32;
  localparam int KEY_W     = 64;
  localparam int KEY_IDX_W = $clog2(KEY_W);
  localparam int RND_W     = $clog2(ROUNDS);
  localparam int SERIAL_W  = 28;
  localparam int TAG_W     = WORD_W - SERIAL_W;

  localparam logic [RND_W-1:0] RND_FIRST = '0;
  localparam logic [RND_W-1:0] RND_LAST  = RND_W'(ROUNDS - 1);

  localparam logic [WORD_W-1:0] NLF_TABLE = 32'h3A5C_742E;
  localparam logic [TAG_W-1:0]  LOW_TAG   = 4'h2;
  localparam logic [TAG_W-1:0]  HIGH_TAG  = 4'h6;

  localparam logic [KEY_W-1:0] MKEY_RESET = 64'h0123_4567_89AB_CDEF;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MKEY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE = 2'd1;

  // Learning mode codes.
  localparam logic MODE_NORMAL = 1'b0;
  localparam logic MODE_SIMPLE = 1'b1;

  // Queue between the front and the round engine.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QDEPTH);

  typedef struct packed {
    logic                mode;
    logic [WORD_W-1:0]   plain;
    logic [SERIAL_W-1:0] serial;
  } queue_item_t;

  typedef struct packed {
    logic        push;
    queue_item_t item;
  } q_wr_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } q_rd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEC_LO,
    ST_DEC_HI,
    ST_ENC
  } eng_state_t;

  function automatic logic nlf(input logic [4:0] idx);
    return NLF_TABLE[idx];
  endfunction

  // One forward round: new bit enters at the top, word shifts right.
  function automatic logic [WORD_W-1:0] enc_round(input logic [WORD_W-1:0] x,
                                                  input logic kbit);
    logic b;
    b = nlf({x[31], x[26], x[20], x[9], x[1]}) ^ x[16] ^ x[0] ^ kbit;
    return {b, x[WORD_W-1:1]};
  endfunction

  // One inverse round: new bit enters at the bottom, word shifts left.
  function automatic logic [WORD_W-1:0] dec_round(input logic [WORD_W-1:0] x,
                                                  input logic kbit);
    logic b;
    b = nlf({x[30], x[25], x[19], x[8], x[0]}) ^ x[15] ^ x[31] ^ kbit;
    return {x[WORD_W-2:0], b};
  endfunction

endpackage

`default_nettype wire

/* rtl/nbc_front.sv */
// Front end: configuration registers and input acceptance.
// Packs each accepted transaction into a queue item; depends on nbc_pkg.
`default_nettype none

module nbc_front
  import nbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [WORD_W-1:0]    in_hop_plain,
  input  wire logic [WORD_W-1:0]    in_serial_word,
  input  wire logic                 q_full,
  output q_wr_t                     q_wr,
  output logic [KEY_W-1:0]          mkey
);

  logic [KEY_W-1:0] mkey_r;
  logic             mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mkey_r <= MKEY_RESET;
      mode_r <= MODE_NORMAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MKEY: mkey_r <= cfg_wdata;
        CFG_IDX_MODE: mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign mkey     = mkey_r;

  // The mode is sampled with the item; the top four serial bits are dropped here.
  always_comb begin
    q_wr.push        = in_valid && !q_full;
    q_wr.item.mode   = mode_r;
    q_wr.item.plain  = in_hop_plain;
    q_wr.item.serial = in_serial_word[SERIAL_W-1:0];
  end

endmodule

`default_nettype wire

/* rtl/nbc_queue.sv */
// Short register queue between the front end and the round engine.
// Depends on nbc_pkg for the item type and depth.
`default_nettype none

module nbc_queue
  import nbc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire q_wr_t q_wr,
  output logic       q_full,
  output q_rd_t      q_rd,
  input  wire logic  q_pop
);

  queue_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]    count_r;
  logic                 do_push, do_pop;

  assign q_full     = (count_r == QCNT_FULL);
  assign q_rd.valid = (count_r != '0);
  assign q_rd.item  = mem_r[rd_ptr_r];

  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && q_rd.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.item;
    end
  end

endmodule

`default_nettype wire

/* rtl/nbc_engine.sv */
// Round engine: derives the device key with two inverse passes, then encrypts.
// One round per cycle, result held in an output register; depends on nbc_pkg.
`default_nettype none

module nbc_engine
  import nbc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_rd_t             q_rd,
  output logic                   q_pop,
  input  wire logic [KEY_W-1:0]  mkey,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_hop_cipher
);

  eng_state_t          state_r, state_nxt;
  logic [RND_W-1:0]    rnd_r, rnd_nxt;
  logic [WORD_W-1:0]   x_r, x_nxt;
  logic [KEY_W-1:0]    dkey_r, dkey_nxt;
  logic                mode_r, mode_nxt;
  logic [WORD_W-1:0]   plain_r, plain_nxt;
  logic [SERIAL_W-1:0] serial_r, serial_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_data_r, out_data_nxt;
  logic [KEY_W-1:0]    enc_key;
  logic [WORD_W-1:0]   dec_x, enc_x;

  assign out_valid      = out_valid_r;
  assign out_hop_cipher = out_data_r;

  assign enc_key = (mode_r == MODE_SIMPLE) ? mkey : dkey_r;
  assign dec_x   = dec_round(x_r, mkey[rnd_r[KEY_IDX_W-1:0]]);
  assign enc_x   = enc_round(x_r, enc_key[rnd_r[KEY_IDX_W-1:0]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r      <= rnd_nxt;
    x_r        <= x_nxt;
    dkey_r     <= dkey_nxt;
    mode_r     <= mode_nxt;
    plain_r    <= plain_nxt;
    serial_r   <= serial_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    x_nxt         = x_r;
    dkey_nxt      = dkey_r;
    mode_nxt      = mode_r;
    plain_nxt     = plain_r;
    serial_nxt    = serial_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    q_pop         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_rd.valid) begin
          q_pop      = 1'b1;
          mode_nxt   = q_rd.item.mode;
          plain_nxt  = q_rd.item.plain;
          serial_nxt = q_rd.item.serial;
          if (q_rd.item.mode == MODE_SIMPLE) begin
            x_nxt     = q_rd.item.plain;
            rnd_nxt   = RND_FIRST;
            state_nxt = ST_ENC;
          end else begin
            x_nxt     = {LOW_TAG, q_rd.item.serial};
            rnd_nxt   = RND_LAST;
            state_nxt = ST_DEC_LO;
          end
        end
      end
      // The inverse passes walk the key schedule from the last round down.
      ST_DEC_LO: begin
        if (rnd_r == RND_FIRST) begin
          dkey_nxt  = {dkey_r[KEY_W-1:WORD_W], dec_x};
          x_nxt     = {HIGH_TAG, serial_r};
          rnd_nxt   = RND_LAST;
          state_nxt = ST_DEC_HI;
        end else begin
          x_nxt   = dec_x;
          rnd_nxt = rnd_r - 1'b1;
        end
      end
      ST_DEC_HI: begin
        if (rnd_r == RND_FIRST) begin
          dkey_nxt  = {dec_x, dkey_r[WORD_W-1:0]};
          x_nxt     = plain_r;
          rnd_nxt   = RND_FIRST;
          state_nxt = ST_ENC;
        end else begin
          x_nxt   = dec_x;
          rnd_nxt = rnd_r - 1'b1;
        end
      end
      ST_ENC: begin
        if (rnd_r != RND_LAST) begin
          x_nxt   = enc_x;
          rnd_nxt = rnd_r + 1'b1;
        end else if (!out_valid_r || out_ready) begin
          // The last round is held back until the output register is free.
          out_data_nxt  = enc_x;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/nlfsr_block_cipher_learned_key.sv */
// Top level of the NLFSR block cipher with learned device keys.
// Instantiates nbc_front, nbc_queue and nbc_engine; depends on nbc_pkg.
//
// Each input transaction carries a 32-bit plaintext hopping word and a serial
// word, and yields one 32-bit ciphertext. In normal-learning mode a 64-bit device
// key is first derived from the low 28 serial bits by two 528-round inverse
// passes under the manufacturer key, and the plaintext is then encrypted for 528
// rounds under that key. In simple mode the plaintext is encrypted directly
// under the manufacturer key. The single round engine runs one round per cycle,
// the last round waiting for a free output register. A two-entry queue in front
// of the engine takes new transactions while it works, and a finished result
// waits in an output register. Registers: index 0 is the 64-bit manufacturer
// key, index 1 the learning mode (0 normal, 1 simple); write them only while the
// block is idle.
`default_nettype none

module nlfsr_block_cipher_learned_key
  import nbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [WORD_W-1:0]    in_hop_plain,
  input  wire logic [WORD_W-1:0]    in_serial_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WORD_W-1:0]         out_hop_cipher
);

  q_wr_t            q_wr;
  q_rd_t            q_rd;
  logic             q_full;
  logic             q_pop;
  logic [KEY_W-1:0] mkey;

  nbc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_hop_plain   (in_hop_plain),
    .in_serial_word (in_serial_word),
    .q_full         (q_full),
    .q_wr           (q_wr),
    .mkey           (mkey)
  );

  nbc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  nbc_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rd           (q_rd),
    .q_pop          (q_pop),
    .mkey           (mkey),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hop_cipher (out_hop_cipher)
  );

endmodule

`default_nettype wire

/* tb/nlfsr_block_cipher_learned_key_tb.sv */
// Self-checking testbench for the NLFSR block cipher with learned device keys.
// Depends on nbc_pkg and nlfsr_block_cipher_learned_key; the cipher is predicted here
// and every ciphertext is compared with the oldest outstanding prediction.
`timescale 1ns / 100ps

module nlfsr_block_cipher_learned_key_tb;
  import nbc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 2;
  localparam int MAX_IDLE     = 8;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 45;
  localparam int DRAIN_CYCLES = 3 * ROUNDS + 16;
  localparam int SETTLE       = 4;

  // Indexes that the block has no register behind.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [KEY_W-1:0]     cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [WORD_W-1:0]    in_hop_plain   = '0;
  logic [WORD_W-1:0]    in_serial_word = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [WORD_W-1:0]    out_hop_cipher;

  // Shadow copy of the configuration registers.
  logic [KEY_W-1:0] mkey_shadow = MKEY_RESET;
  logic             mode_shadow = MODE_NORMAL;

  logic [WORD_W-1:0] cipher_due_q[$];
  int                fail_count    = 0;
  int                items_sent    = 0;
  int                ciphers_seen  = 0;
  int                cfg_writes    = 0;
  int                simple_items  = 0;
  bit                burst         = 1'b0;

  nlfsr_block_cipher_learned_key i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_hop_plain   (in_hop_plain),
    .in_serial_word (in_serial_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hop_cipher (out_hop_cipher)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [WORD_W-1:0] forward_rounds(input logic [WORD_W-1:0] word,
                                                       input logic [KEY_W-1:0] key);
    logic [WORD_W-1:0] x;
    logic [4:0]        sel;
    logic              fb;
    x = word;
    for (int r = 0; r < ROUNDS; r++) begin
      sel = {x[31], x[26], x[20], x[9], x[1]};
      fb  = NLF_TABLE[sel] ^ x[16] ^ x[0] ^ key[r % KEY_W];
      x   = {fb, x[31:1]};
    end
    return x;
  endfunction

  // The inverse walks the key schedule backwards and shifts the other way.
  function automatic logic [WORD_W-1:0] inverse_rounds(input logic [WORD_W-1:0] word,
                                                       input logic [KEY_W-1:0] key);
    logic [WORD_W-1:0] x;
    logic [4:0]        sel;
    logic              fb;
    x = word;
    for (int r = ROUNDS - 1; r >= 0; r--) begin
      sel = {x[30], x[25], x[19], x[8], x[0]};
      fb  = NLF_TABLE[sel] ^ x[15] ^ x[31] ^ key[r % KEY_W];
      x   = {x[30:0], fb};
    end
    return x;
  endfunction

  function automatic logic [WORD_W-1:0] predict_cipher(input logic [WORD_W-1:0] plain,
                                                       input logic [WORD_W-1:0] serial);
    logic [KEY_W-1:0] key;
    if (mode_shadow == MODE_NORMAL) begin
      key = {inverse_rounds({HIGH_TAG, serial[SERIAL_W-1:0]}, mkey_shadow),
             inverse_rounds({LOW_TAG, serial[SERIAL_W-1:0]}, mkey_shadow)};
    end else begin
      key = mkey_shadow;
    end
    return forward_rounds(plain, key);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_IDX_MKEY) begin
      mkey_shadow = data;
    end else if (idx == CFG_IDX_MODE) begin
      mode_shadow = data[0];
    end
    cfg_writes++;
  endtask

  // Drops the input valid and waits until every outstanding ciphertext is back.
  task automatic wait_all_done();
    in_valid <= 1'b0;
    while (cipher_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Valid is left high after acceptance so that back-to-back transactions need
  // only one assignment per edge.
  task automatic send_hop(input logic [WORD_W-1:0] plain, input logic [WORD_W-1:0] serial);
    int                gap;
    logic [WORD_W-1:0] due;
    gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
    due = predict_cipher(plain, serial);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_hop_plain   <= plain;
    in_serial_word <= serial;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    cipher_due_q.push_back(due);
    items_sent++;
    if (mode_shadow == MODE_SIMPLE) simple_items++;
  endtask

  task automatic test_reset_defaults();
    send_hop(32'h0000_0000, 32'h0000_0000);
    send_hop(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // The top four serial bits must not change the derived key.
    send_hop(32'h1234_5678, 32'h0ABC_DEF1);
    send_hop(32'h1234_5678, 32'hFABC_DEF1);
  endtask

  task automatic test_simple_mode();
    wait_all_done();
    write_reg(CFG_IDX_MODE, 64'd1);
    write_reg(CFG_IDX_MKEY, 64'h0);
    send_hop(32'h0000_0000, 32'h0000_0000);
    send_hop(32'hFFFF_FFFF, 32'h0000_0000);
    wait_all_done();
    write_reg(CFG_IDX_MKEY, '1);
    send_hop(32'h0000_0000, 32'hFFFF_FFFF);
    send_hop(32'hFFFF_FFFF, 32'h5A5A_A5A5);
  endtask

  task automatic test_wide_mode_value();
    // Only bit 0 of the mode write counts.
    wait_all_done();
    write_reg(CFG_IDX_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_hop(32'hDEAD_BEEF, 32'h0765_4321);
    wait_all_done();
    write_reg(CFG_IDX_MODE, 64'h8000_0000_0000_0003);
    send_hop(32'hDEAD_BEEF, 32'h0765_4321);
  endtask

  task automatic test_spare_index();
    wait_all_done();
    write_reg(CFG_IDX_MODE, {$urandom, $urandom} & ~64'd1);
    write_reg(CFG_IDX_MKEY, {$urandom, $urandom});
    write_reg(CFG_IDX_SPARE_LO, '1);
    write_reg(CFG_IDX_SPARE_HI, {$urandom, $urandom} | 64'd1);
    send_hop($urandom, $urandom);
    send_hop($urandom, $urandom);
    send_hop($urandom, $urandom);
  endtask

  task automatic test_random_phases();
    logic [KEY_W-1:0] key;
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_all_done();
      case (p)
        3:       key = '1;
        5:       key = '0;
        default: key = {$urandom, $urandom};
      endcase
      write_reg(CFG_IDX_MKEY, key);
      write_reg(CFG_IDX_MODE, (p % 2 == 0) ? 64'(MODE_NORMAL) : 64'(MODE_SIMPLE));
      burst = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Let the block run completely dry once in the middle of a phase.
        if (p == 2 && n == PHASE_ITEMS / 2) wait_all_done();
        send_hop($urandom, $urandom);
      end
      burst = 1'b0;
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_simple_mode();
    test_wide_mode_value();
    test_spare_index();
    test_random_phases();
    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d transactions (%0d in simple mode) with %0d register writes,",
             items_sent, simple_items, cfg_writes);
    $display("including key extremes, ignored indexes and %0d checked ciphertexts.",
             ciphers_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: sometimes ready waits ahead of valid, sometimes it holds off
  // for a while after valid has risen.
  initial begin : result_monitor
    int                stall;
    logic [WORD_W-1:0] due;
    wait (rst_n === 1'b1);
    forever begin
      stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        do @(posedge clk); while (out_valid !== 1'b1);
        repeat (stall - 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      ciphers_seen++;
      if (cipher_due_q.size() == 0) begin
        $error("hop_cipher: no transaction outstanding, actual %h", out_hop_cipher);
        fail_count++;
      end else begin
        due = cipher_due_q.pop_front();
        if (out_hop_cipher !== due) begin
          $error("hop_cipher: expected %h, actual %h", due, out_hop_cipher);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
